// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
// spq_pkg: operation and status codes, controller/datapath command and status structs.
// No dependencies. Used by every module of sorted_priority_queue.
package spq_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic    latch;
    logic    set_status;
    status_e status;
    logic    pop;
    logic    clear;
    logic    rd_prev;
    logic    shift;
    logic    place;
    logic    rd_head;
    logic    rd_tail;
    logic    cap_head;
    logic    cap_tail;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic less;
  } sts_t;

endpackage

// ===== hdl/spq_ctrl.sv =====
`timescale 1ns / 1ps
// spq_ctrl: sequencer for insert scan, remove, clear, head/tail readback and output hand-off.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  spq_pkg::sts_t       sts_i,
  output spq_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_HRD,
    S_TRD,
    S_TCAP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   accept;
  spq_pkg::op_e op;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign op          = spq_pkg::op_e'(op_i);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch      = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = spq_pkg::ST_OK;
          state_d          = S_HRD;
          case (op)
            spq_pkg::OP_INSERT: begin
              if (sts_i.full) begin
                cmd_o.status = spq_pkg::ST_FULL;
              end else begin
                state_d = S_INS_CHK;
              end
            end
            spq_pkg::OP_REMOVE: begin
              if (sts_i.empty) begin
                cmd_o.status = spq_pkg::ST_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
              end
            end
            spq_pkg::OP_READ: begin
              if (sts_i.empty) begin
                cmd_o.status = spq_pkg::ST_EMPTY;
              end
            end
            default: begin
              cmd_o.clear = 1'b1;
            end
          endcase
        end
      end
      S_INS_CHK: begin
        if (sts_i.idx_zero) begin
          cmd_o.place = 1'b1;
          state_d     = S_HRD;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.less) begin
          cmd_o.shift = 1'b1;
          state_d     = S_INS_CHK;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_HRD;
        end
      end
      S_HRD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_TRD;
      end
      S_TRD: begin
        cmd_o.cap_head = 1'b1;
        cmd_o.rd_tail  = 1'b1;
        state_d        = S_TCAP;
      end
      S_TCAP: begin
        cmd_o.cap_tail = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/spq_dp.sv =====
`timescale 1ns / 1ps
// spq_dp: circular entry store, fill and head pointer, scan index, result registers.
// Depends on spq_pkg.
module spq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [spq_pkg::DataW-1:0]   value_i,
  input  spq_pkg::cmd_t                      cmd_i,
  output spq_pkg::sts_t                      sts_o,
  output logic [1:0]                         status_o,
  output logic signed [spq_pkg::DataW-1:0]   head_value_o,
  output logic signed [spq_pkg::DataW-1:0]   tail_value_o,
  output logic                               is_empty_o,
  output logic [spq_pkg::CountW-1:0]         count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);

  logic signed [spq_pkg::DataW-1:0] mem [DEPTH];
  logic signed [spq_pkg::DataW-1:0] rdata_q, val_q, headv_q, tailv_q;
  logic [AW-1:0] hptr_q;
  logic [FW-1:0] fill_q, idx_q;
  spq_pkg::status_e status_q;

  logic [1:0]                       out_status_q;
  logic signed [spq_pkg::DataW-1:0] out_head_q, out_tail_q;
  logic                             out_empty_q;
  logic [spq_pkg::CountW-1:0]       out_count_q;

  logic [AW-1:0] rlog, raddr, waddr;
  logic          rd_en, we;
  logic signed [spq_pkg::DataW-1:0] wdata;
  logic          empty;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hp, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, hp} + {1'b0, l};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign empty = (fill_q == '0);

  assign sts_o.full     = (fill_q == FW'(DEPTH));
  assign sts_o.empty    = empty;
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.less     = (rdata_q < val_q);

  always_comb begin
    rlog = '0;
    if (cmd_i.rd_prev) begin
      rlog = AW'(idx_q - FW'(1));
    end else if (cmd_i.rd_tail && !empty) begin
      rlog = AW'(fill_q - FW'(1));
    end
  end

  assign raddr = phys(hptr_q, rlog);
  assign rd_en = cmd_i.rd_prev | cmd_i.rd_head | cmd_i.rd_tail;
  assign we    = cmd_i.shift | cmd_i.place;
  assign waddr = phys(hptr_q, AW'(idx_q));
  assign wdata = cmd_i.shift ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      hptr_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        fill_q <= '0;
      end else if (cmd_i.pop) begin
        fill_q <= fill_q - FW'(1);
        hptr_q <= (hptr_q == AW'(DEPTH - 1)) ? '0 : hptr_q + AW'(1);
      end else if (cmd_i.place) begin
        fill_q <= fill_q + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      val_q <= value_i;
      idx_q <= fill_q;
    end else if (cmd_i.shift) begin
      idx_q <= idx_q - FW'(1);
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.cap_head) begin
      headv_q <= empty ? '0 : rdata_q;
    end
    if (cmd_i.cap_tail) begin
      tailv_q <= empty ? '0 : rdata_q;
    end
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_head_q   <= headv_q;
      out_tail_q   <= tailv_q;
      out_empty_q  <= empty;
      out_count_q  <= spq_pkg::CountW'(fill_q);
    end
  end

  assign status_o     = out_status_q;
  assign head_value_o = out_head_q;
  assign tail_value_o = out_tail_q;
  assign is_empty_o   = out_empty_q;
  assign count_o      = out_count_q;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// sorted_priority_queue: top level, controller plus datapath of a descending-order queue.
// Depends on spq_pkg, spq_ctrl, spq_dp.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i / in_ready_o  | op_i, value_i
//   out     | output    | out_valid_o / out_ready_i| status_o, head_value_o, tail_value_o,
//           |           |                          | is_empty_o, count_o
//
// Remove, read, clear and a dropped insert go from accept through S_HRD, S_TRD, S_TCAP, S_DONE.
// Insert scans from the tail in S_INS_CHK/S_INS_CMP, moving each stored entry smaller than the
// new word one place; each moved entry costs one read and one write of the entry store.
// One word in flight; a new word is taken while the previous result waits on out.
// Reset empties the queue at once; stored entries keep stale data, never passed to out.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic signed [spq_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic signed [spq_pkg::DataW-1:0] head_value_o,
  output logic signed [spq_pkg::DataW-1:0] tail_value_o,
  output logic                             is_empty_o,
  output logic [spq_pkg::CountW-1:0]       count_o
);

  spq_pkg::cmd_t cmd;
  spq_pkg::sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .status_o     (status_o),
    .head_value_o (head_value_o),
    .tail_value_o (tail_value_o),
    .is_empty_o   (is_empty_o),
    .count_o      (count_o)
  );

endmodule

// ===== hdl/spq_checker.sv =====
`timescale 1ns / 1ps
// spq_checker: port-level checks on the result channel of sorted_priority_queue.
// Depends on spq_pkg; bound to sorted_priority_queue below.
module spq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [1:0]                       status_i,
  input logic signed [spq_pkg::DataW-1:0] head_value_i,
  input logic signed [spq_pkg::DataW-1:0] tail_value_i,
  input logic                             is_empty_i,
  input logic [spq_pkg::CountW-1:0]       count_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(head_value_i)
      && $stable(tail_value_i) && $stable(status_i) && $stable(count_i))
    else $error("result word changed under stall");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_empty_i |-> count_i == '0 && head_value_i == '0 && tail_value_i == '0)
    else $error("empty result carries data");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_empty_i |-> head_value_i >= tail_value_i)
    else $error("head below tail");

  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == spq_pkg::ST_FULL |-> !is_empty_i)
    else $error("full status on empty queue");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == spq_pkg::ST_EMPTY |-> is_empty_i)
    else $error("empty status on non-empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_i     (status_o),
  .head_value_i (head_value_o),
  .tail_value_i (tail_value_o),
  .is_empty_i   (is_empty_o),
  .count_i      (count_o)
);
